FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the core; sampled on clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold a condition at every edge
`define CLSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when the first holds, the second must hold in the following cycle
`define CLSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/clsu_pkg.sv
package clsu_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;

  localparam int ACT_W      = 3;
  localparam int IDX_IN_W   = 6;
  localparam int VAL_IN_W   = 32;
  localparam int RD_OUT_W   = 32;
  localparam int ST_W       = 2;
  localparam int CNT_OUT_W  = 7;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

  localparam int GRP   = 8;
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                   app;
    logic                   wr;
    logic                   rm;
    logic [IDX_IN_W-1:0]    idx;
    logic [CNT_W-1:0]       count;
    logic [VALUE_WIDTH-1:0] val;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/clsu_in_if.sv
interface clsu_in_if import clsu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [IDX_IN_W-1:0] index;
  logic [VAL_IN_W-1:0] value;

  modport source (output valid, output action, output index, output value, input ready);
  modport sink   (input valid, input action, input index, input value, output ready);
endinterface

FILE: rtl/core/clsu_out_if.sv
interface clsu_out_if import clsu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RD_OUT_W-1:0]  read_value;
  logic [ST_W-1:0]      status;
  logic [CNT_OUT_W-1:0] count;
  logic                 empty_res;
  logic                 full_res;

  modport source (output valid, output read_value, output status, output count,
                  output empty_res, output full_res, input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  input empty_res, input full_res, output ready);
endinterface

FILE: rtl/core/clsu_cell.sv
module clsu_cell import clsu_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [IDX_W-1:0]       pos,
  input  cell_ctrl_t             ctrl,
  input  logic [VALUE_WIDTH-1:0] nbr_val,
  output logic [VALUE_WIDTH-1:0] val
);

  logic [VALUE_WIDTH-1:0] val_r;
  logic [CMP_W-1:0]       pos_c;
  logic [CMP_W-1:0]       pos_inc;
  logic [CMP_W-1:0]       idx_c;
  logic [CMP_W-1:0]       cnt_c;
  logic                   load;
  logic                   shift;

  assign pos_c   = CMP_W'(pos);
  assign pos_inc = pos_c + CMP_W'(1);
  assign idx_c   = CMP_W'(ctrl.idx);
  assign cnt_c   = CMP_W'(ctrl.count);

  assign load  = (ctrl.app && (pos_c == cnt_c)) || (ctrl.wr && (pos_c == idx_c));
  assign shift = ctrl.rm && (pos_c >= idx_c) && (pos_inc < cnt_c);

  always_ff @(posedge clk) begin
    if (en && load) begin
      val_r <= ctrl.val;
    end else if (en && shift) begin
      val_r <= nbr_val;
    end
  end

  assign val = val_r;

endmodule

FILE: rtl/core/clsu_gather.sv
module clsu_gather import clsu_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [IDX_IN_W-1:0]    idx,
  input  logic [VALUE_WIDTH-1:0] vals [DEPTH],
  output logic [VALUE_WIDTH-1:0] rd_val
);

  logic [VALUE_WIDTH-1:0] grp_r   [NGRP];
  logic [VALUE_WIDTH-1:0] grp_nxt [NGRP];
  logic [CMP_W-1:0]       idx_c;

  assign idx_c = CMP_W'(idx);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if ((g * GRP + k) < DEPTH) begin
          if (CMP_W'(g * GRP + k) == idx_c) begin
            grp_nxt[g] = grp_nxt[g] | vals[g * GRP + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
    end
  end

  always_comb begin
    rd_val = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_val = rd_val | grp_r[g];
    end
  end

endmodule

FILE: rtl/core/compacting_list_store_unit.sv
// An accepted item passes the decode register, then the cell update, then the result register.
// One item is in flight at a time: the next item enters once its predecessor has moved into
// the output register, and a stalled output holds the input.
// Reset (rst_n low, synchronous): count to zero, no item in flight, no result pending.
// Entry cells have no reset; only entries below the count are ever read.
`include "assert_macros.svh"

module compacting_list_store_unit import clsu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  clsu_in_if.sink           in_ch,
  clsu_out_if.source        out_ch
);

  logic                   a_v_r;
  logic [ACT_W-1:0]       a_act_r;
  logic [IDX_IN_W-1:0]    a_idx_r;
  logic [VALUE_WIDTH-1:0] a_val_r;

  logic                   b_v_r;
  logic                   b_rd_r;
  status_t                b_st_r;

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  logic                   out_v_r;
  logic [RD_OUT_W-1:0]    out_rd_r;
  logic [ST_W-1:0]        out_st_r;
  logic [CNT_OUT_W-1:0]   out_cnt_r;
  logic                   out_empty_r;
  logic                   out_full_r;

  logic                   in_fire;
  logic                   out_load;
  logic                   idx_ok;
  logic                   rd_ok;
  status_t                st;
  cell_ctrl_t             ctrl;

  logic [VALUE_WIDTH-1:0] vals [DEPTH];
  logic [VALUE_WIDTH-1:0] gather_val;

  assign in_ch.ready = !a_v_r && !b_v_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = b_v_r && (!out_v_r || out_ch.ready);

  assign idx_ok = CMP_W'(a_idx_r) < CMP_W'(count_r);

  always_comb begin
    ctrl.app   = 1'b0;
    ctrl.wr    = 1'b0;
    ctrl.rm    = 1'b0;
    ctrl.idx   = a_idx_r;
    ctrl.count = count_r;
    ctrl.val   = a_val_r;
    count_nxt  = count_r;
    rd_ok      = 1'b0;
    st         = ST_OK;
    case (action_t'(a_act_r))
      ACT_APPEND: begin
        if (count_r == CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else begin
          ctrl.app  = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_READ: begin
        if (idx_ok) rd_ok = 1'b1;
        else st = ST_RANGE;
      end
      ACT_WRITE: begin
        if (idx_ok) ctrl.wr = 1'b1;
        else st = ST_RANGE;
      end
      ACT_REMOVE: begin
        if (idx_ok) begin
          ctrl.rm   = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          st = ST_RANGE;
        end
      end
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] nbr;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = vals[i + 1];
    end else begin : g_top
      assign nbr = vals[i];
    end
    clsu_cell u_cell (
      .clk     (clk),
      .en      (a_v_r),
      .pos     (IDX_W'(i)),
      .ctrl    (ctrl),
      .nbr_val (nbr),
      .val     (vals[i])
    );
  end

  clsu_gather u_gather (
    .clk    (clk),
    .en     (a_v_r),
    .idx    (a_idx_r),
    .vals   (vals),
    .rd_val (gather_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      count_r <= '0;
    end else begin
      if (in_fire) begin
        a_v_r <= 1'b1;
      end else if (a_v_r) begin
        a_v_r <= 1'b0;
      end
      if (a_v_r) begin
        b_v_r   <= 1'b1;
        count_r <= count_nxt;
      end else if (out_load) begin
        b_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_act_r <= in_ch.action;
      a_idx_r <= in_ch.index;
      a_val_r <= VALUE_WIDTH'(in_ch.value);
    end
    if (a_v_r) begin
      b_rd_r <= rd_ok;
      b_st_r <= st;
    end
    if (out_load) begin
      out_rd_r    <= b_rd_r ? RD_OUT_W'(gather_val) : '0;
      out_st_r    <= b_st_r;
      out_cnt_r   <= CNT_OUT_W'(count_r);
      out_empty_r <= (count_r == '0);
      out_full_r  <= (count_r == CNT_W'(DEPTH));
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.count      = out_cnt_r;
  assign out_ch.empty_res  = out_empty_r;
  assign out_ch.full_res   = out_full_r;

  `CLSU_ASSERT(a_cnt_bound, count_r <= CNT_W'(DEPTH), "entry count beyond capacity")
  `CLSU_ASSERT(a_one_item, !(a_v_r && b_v_r), "two items in flight")
  `CLSU_ASSERT_NEXT(a_take, in_fire, a_v_r, "accepted item not decoded")
  `CLSU_ASSERT_NEXT(a_exec, a_v_r, b_v_r && !a_v_r, "update cycle did not advance")

endmodule

FILE: sim/list_store_monitor.sv
`timescale 1ns / 1ps

module list_store_monitor import clsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  clsu_in_if   in_ch,
  clsu_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [RD_OUT_W-1:0]  read_value;
    logic [ST_W-1:0]      status;
    logic [CNT_OUT_W-1:0] count;
    logic                 empty_res;
    logic                 full_res;
  } list_result_t;

  logic [VALUE_WIDTH-1:0] cells [DEPTH];
  int unsigned            held;
  list_result_t           awaited_q [$];
  int                     faults;

  function automatic list_result_t apply_action(input logic [ACT_W-1:0] act,
                                                input logic [IDX_IN_W-1:0] idx,
                                                input logic [VAL_IN_W-1:0] val);
    list_result_t r;
    logic         in_range;
    int unsigned  p;
    r = '0;
    r.status = ST_OK;
    in_range = (idx < held);
    case (act)
      ACT_APPEND: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cells[held] = val[VALUE_WIDTH-1:0];
          held++;
        end
      end
      ACT_READ: begin
        if (in_range) r.read_value = RD_OUT_W'(cells[idx]);
        else r.status = ST_RANGE;
      end
      ACT_WRITE: begin
        if (in_range) cells[idx] = val[VALUE_WIDTH-1:0];
        else r.status = ST_RANGE;
      end
      ACT_REMOVE: begin
        if (in_range) begin
          for (p = idx; p + 1 < held; p++) cells[p] = cells[p + 1];
          held--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      ACT_CLEAR: held = 0;
      default: ;
    endcase
    r.count     = CNT_OUT_W'(held);
    r.empty_res = (held == 0);
    r.full_res  = (held == DEPTH);
    return r;
  endfunction

  task automatic note_fault(input string what);
    faults++;
    if (faults <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      held = 0;
      awaited_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.read_value = out_ch.read_value;
        got.status     = out_ch.status;
        got.count      = out_ch.count;
        got.empty_res  = out_ch.empty_res;
        got.full_res   = out_ch.full_res;
        if (awaited_q.size() == 0) begin
          note_fault($sformatf("result transfer with none awaited: value %h status %0d count %0d",
                               got.read_value, got.status, got.count));
        end else begin
          want = awaited_q.pop_front();
          if (got !== want)
            note_fault($sformatf({"mismatch: expected value %h status %0d count %0d ",
                                  "empty %b full %b, got value %h status %0d count %0d ",
                                  "empty %b full %b"},
                                 want.read_value, want.status, want.count, want.empty_res,
                                 want.full_res, got.read_value, got.status, got.count,
                                 got.empty_res, got.full_res));
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_q.push_back(apply_action(in_ch.action, in_ch.index, in_ch.value));
    end
    pending    <= awaited_q.size();
    fail_count <= faults;
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import clsu_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_MID   = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
  localparam int               RANDOM_ITEMS    = 800;

  logic        clk = 1'b0;
  logic        rst_n;
  int          fail_count;
  int          pending;
  bit          steady;
  int unsigned stock;
  int unsigned issued;

  clsu_in_if  in_ch ();
  clsu_out_if out_ch ();

  compacting_list_store_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_store_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int held_index();
    if (stock == 0) return $urandom_range(0, DEPTH - 1);
    return $urandom_range(0, stock - 1);
  endfunction

  function automatic int stray_index();
    if (stock >= DEPTH) return DEPTH - 1;
    return $urandom_range(stock, DEPTH - 1);
  endfunction

  task automatic send_item(input int act_i, input int idx_i,
                           input logic [VAL_IN_W-1:0] val);
    logic [ACT_W-1:0]    act;
    logic [IDX_IN_W-1:0] idx;
    int                  gap;
    act = ACT_W'(act_i);
    idx = IDX_IN_W'(idx_i);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.index  = idx;
    in_ch.value  = val;
    do @(posedge clk); while (!in_ch.ready);
    case (act)
      ACT_APPEND: if (stock < DEPTH) stock++;
      ACT_REMOVE: if (idx < stock) stock--;
      ACT_CLEAR:  stock = 0;
      default: ;
    endcase
    if (act <= ACT_CLEAR) issued++;
  endtask

  // hold off until every awaited result has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic mixed_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 || (stock < 4 && r < 50)) send_item(ACT_APPEND, $urandom, $urandom);
    else if (r < 55) send_item(ACT_READ, held_index(), $urandom);
    else if (r < 72) send_item(ACT_WRITE, held_index(), $urandom);
    else if (r < 87) send_item(ACT_REMOVE, held_index(), $urandom);
    else if (r < 89) send_item(ACT_CLEAR, $urandom, $urandom);
    else if (r < 92) send_item($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST), $urandom,
                               $urandom);
    else if (r < 95) send_item(ACT_READ, stray_index(), $urandom);
    else if (r < 97) send_item(ACT_WRITE, stray_index(), $urandom);
    else send_item(ACT_REMOVE, stray_index(), $urandom);
  endtask

  initial begin
    rst_n         = 1'b0;
    steady        = 1'b0;
    stock         = 0;
    issued        = 0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_APPEND;
    in_ch.index   = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(ACT_READ, 0, '0);
    send_item(ACT_REMOVE, 0, '0);
    send_item(ACT_WRITE, DEPTH - 1, '1);
    send_item(ACT_CLEAR, 0, '0);
    send_item(ACT_APPEND, 0, 32'h0000_0000);
    send_item(ACT_APPEND, 0, 32'hFFFF_FFFF);
    send_item(ACT_APPEND, 0, 32'h1234_5678);
    send_item(ACT_APPEND, 0, 32'h89AB_CDEF);
    send_item(ACT_READ, 0, '0);
    send_item(ACT_READ, 1, '0);
    send_item(ACT_READ, 3, '0);
    send_item(ACT_READ, 4, '0);
    send_item(ACT_WRITE, 2, 32'hA5A5_A5A5);
    send_item(ACT_READ, 2, '1);
    send_item(ACT_REMOVE, 0, '0);
    send_item(ACT_READ, 0, '0);
    send_item(ACT_REMOVE, 2, '0);
    send_item(ACT_READ, 2, '0);
    send_item(ACT_SPARE_FIRST, 1, 32'h5A5A_5A5A);
    send_item(ACT_SPARE_MID, 0, '1);
    send_item(ACT_SPARE_LAST, DEPTH - 1, '1);
    send_item(ACT_READ, 1, '0);
    send_item(ACT_CLEAR, DEPTH - 1, '1);
    send_item(ACT_READ, 0, '0);
    send_item(ACT_APPEND, DEPTH - 1, 32'hDEAD_BEEF);
    drain();

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0: begin
          while (stock < DEPTH) send_item(ACT_APPEND, $urandom, $urandom);
          repeat ($urandom_range(1, 2)) send_item(ACT_APPEND, $urandom, $urandom);
          send_item(ACT_READ, DEPTH - 1, $urandom);
          send_item(ACT_WRITE, DEPTH - 1, $urandom);
          send_item(ACT_READ, $urandom_range(0, DEPTH - 1), $urandom);
          send_item(ACT_REMOVE, $urandom_range(0, DEPTH - 1), $urandom);
        end
        1: begin
          while (stock > 0) begin
            case ($urandom_range(0, 2))
              0: send_item(ACT_REMOVE, 0, $urandom);
              1: send_item(ACT_REMOVE, stock - 1, $urandom);
              default: send_item(ACT_REMOVE, held_index(), $urandom);
            endcase
            if ($urandom_range(0, 3) == 0) send_item(ACT_READ, held_index(), $urandom);
          end
        end
        2: begin
          send_item(ACT_CLEAR, $urandom, $urandom);
          repeat ($urandom_range(1, 8)) send_item(ACT_APPEND, $urandom, $urandom);
        end
        3: begin
          repeat ($urandom_range(1, 8))
            send_item($urandom_range(0, 7), $urandom_range(0, DEPTH - 1), $urandom);
        end
        default: begin
          repeat ($urandom_range(5, 20)) mixed_item();
        end
      endcase
      if ($urandom_range(0, 19) == 0) drain();
    end
    steady = 1'b0;
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/clsu_pkg.sv
rtl/core/clsu_in_if.sv
rtl/core/clsu_out_if.sv
rtl/core/clsu_cell.sv
rtl/core/clsu_gather.sv
rtl/core/compacting_list_store_unit.sv
sim/list_store_monitor.sv
sim/testbench.sv
